// ----- sv/assert_macros.svh -----
// assertion macros shared by the list rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define BSL_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("list check failed");

// consequent holds in the same cycle as the antecedent
`define BSL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list check failed");

// consequent holds in the cycle after the antecedent
`define BSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list check failed");

`endif

// ----- sv/bsl_pkg.sv -----
// types, codes and sizes for the bounded sequential list
// used by bsl_cmp and bounded_sequential_list
package bsl_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // request kinds
  localparam logic [2:0] KIND_APPEND    = 3'd0;
  localparam logic [2:0] KIND_PREPEND   = 3'd1;
  localparam logic [2:0] KIND_SORTED    = 3'd2;
  localparam logic [2:0] KIND_REM_FIRST = 3'd3;
  localparam logic [2:0] KIND_REM_LAST  = 3'd4;
  localparam logic [2:0] KIND_REM_AT    = 3'd5;
  localparam logic [2:0] KIND_SEARCH    = 3'd6;

  // result status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADIDX   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [3:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] removed_value;
    logic [3:0]         found_position;
    logic [4:0]         entry_count;
  } out_item_t;

  // compare unit result
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EX,
    S_OUT
  } seq_st_t;

endpackage

// ----- sv/bsl_cmp.sv -----
// shared word compare unit: signed greater-than and equality
// depends on bsl_pkg
module bsl_cmp (
  input  bsl_pkg::word_t    a,
  input  bsl_pkg::word_t    b,
  output bsl_pkg::cmp_res_t res
);

  // signed order for sorting, bitwise match for search
  assign res.gt = $signed(a) > $signed(b);
  assign res.eq = (a == b);

endmodule

// ----- sv/bounded_sequential_list.sv -----
// bounded sequential list: one request at a time, stall high while busy.
// append and refused requests go straight to the result. prepend, removals and
// search walk the list entry by entry through one read port. sorted insert runs
// bubble passes over the shared compare unit.
// sync active-low reset empties the list; entry storage itself is not cleared.
`include "assert_macros.svh"

module bounded_sequential_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bsl_pkg::out_item_t  out_data
);

  localparam int IDX_W = bsl_pkg::IDX_W;
  localparam int CNT_W = bsl_pkg::CNT_W;

  // control registers
  bsl_pkg::seq_st_t   state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic               head_r, head_nxt;
  logic               swap_r, swap_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload registers
  bsl_pkg::word_t     val_r, val_nxt;
  bsl_pkg::word_t     carry_r, carry_nxt;
  bsl_pkg::word_t     removed_r, removed_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [3:0]         found_r, found_nxt;
  bsl_pkg::out_item_t out_data_r, out_data_nxt;

  // entry storage, one write and one registered read port
  bsl_pkg::word_t     mem [bsl_pkg::CAPACITY];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  bsl_pkg::word_t     mem_wd;
  logic [IDX_W-1:0]   mem_ra;
  bsl_pkg::word_t     rd_data_r;

  bsl_pkg::word_t     cmp_a;
  bsl_pkg::cmp_res_t  cmp_res;
  logic               in_acc;
  bsl_pkg::word_t     in_word;
  logic               full;

  assign in_stall  = (state_r != bsl_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_word   = bsl_pkg::WORD_BITS'(in_data.value);
  assign full      = (count_r >= CNT_W'(bsl_pkg::CAPACITY));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one compare unit serves sort passes and search
  assign cmp_a = (kind_r == bsl_pkg::KIND_SEARCH) ? val_r : carry_r;

  bsl_cmp u_cmp (
    .a   (cmp_a),
    .b   (rd_data_r),
    .res (cmp_res)
  );

  // storage ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsl_pkg::S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      lim_r       <= '0;
      kind_r      <= bsl_pkg::KIND_APPEND;
      head_r      <= 1'b0;
      swap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      lim_r       <= lim_nxt;
      kind_r      <= kind_nxt;
      head_r      <= head_nxt;
      swap_r      <= swap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    carry_r    <= carry_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    lim_nxt       = lim_r;
    kind_nxt      = kind_r;
    head_nxt      = head_r;
    swap_nxt      = swap_r;
    val_nxt       = val_r;
    carry_nxt     = carry_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = carry_r;
    mem_ra        = '0;

    case (state_r)
      bsl_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_nxt    = in_data.kind;
          val_nxt     = in_word;
          status_nxt  = bsl_pkg::ST_DONE;
          removed_nxt = '0;
          found_nxt   = '0;
          head_nxt    = 1'b1;
          swap_nxt    = 1'b0;
          ptr_nxt     = '0;
          lim_nxt     = count_r + 1'b1;
          state_nxt   = bsl_pkg::S_OUT;
          case (in_data.kind)
            bsl_pkg::KIND_APPEND, bsl_pkg::KIND_SORTED: begin
              if (full) begin
                status_nxt = bsl_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = count_r[IDX_W-1:0];
                mem_wd    = in_word;
                count_nxt = count_r + 1'b1;
                if (in_data.kind == bsl_pkg::KIND_SORTED && count_r != '0) begin
                  state_nxt = bsl_pkg::S_RD;
                end
              end
            end
            bsl_pkg::KIND_PREPEND: begin
              if (full) begin
                status_nxt = bsl_pkg::ST_FULL;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = bsl_pkg::S_RD;
              end
            end
            bsl_pkg::KIND_REM_FIRST, bsl_pkg::KIND_REM_LAST, bsl_pkg::KIND_REM_AT: begin
              if (count_r == '0) begin
                status_nxt = bsl_pkg::ST_EMPTY;
              end else if (in_data.kind == bsl_pkg::KIND_REM_AT &&
                           CNT_W'(in_data.index) >= count_r) begin
                status_nxt = bsl_pkg::ST_BADIDX;
              end else begin
                if (in_data.kind == bsl_pkg::KIND_REM_LAST) begin
                  ptr_nxt = count_r - 1'b1;
                end else if (in_data.kind == bsl_pkg::KIND_REM_AT) begin
                  ptr_nxt = CNT_W'(in_data.index);
                end
                state_nxt = bsl_pkg::S_RD;
              end
            end
            bsl_pkg::KIND_SEARCH: begin
              state_nxt = bsl_pkg::S_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // issue a read or close the walk
      bsl_pkg::S_RD: begin
        case (kind_r)
          bsl_pkg::KIND_PREPEND: begin
            if (ptr_r == '0) begin
              mem_we    = 1'b1;
              mem_wa    = '0;
              mem_wd    = val_r;
              count_nxt = count_r + 1'b1;
              state_nxt = bsl_pkg::S_OUT;
            end else begin
              mem_ra    = IDX_W'(ptr_r - 1'b1);
              state_nxt = bsl_pkg::S_EX;
            end
          end
          bsl_pkg::KIND_SORTED: begin
            if (head_r) begin
              mem_ra    = '0;
              state_nxt = bsl_pkg::S_EX;
            end else if (ptr_r >= lim_r) begin
              // largest word of this pass lands at the end
              mem_we = 1'b1;
              mem_wa = IDX_W'(lim_r - 1'b1);
              mem_wd = carry_r;
              if (swap_r && lim_r > CNT_W'(2)) begin
                lim_nxt  = lim_r - 1'b1;
                head_nxt = 1'b1;
                swap_nxt = 1'b0;
                ptr_nxt  = '0;
              end else begin
                state_nxt = bsl_pkg::S_OUT;
              end
            end else begin
              mem_ra    = IDX_W'(ptr_r);
              state_nxt = bsl_pkg::S_EX;
            end
          end
          bsl_pkg::KIND_SEARCH: begin
            if (ptr_r >= count_r) begin
              status_nxt = bsl_pkg::ST_NOTFOUND;
              state_nxt  = bsl_pkg::S_OUT;
            end else begin
              mem_ra    = IDX_W'(ptr_r);
              state_nxt = bsl_pkg::S_EX;
            end
          end
          default: begin
            // removals: fetch the victim, then pull the tail down
            if (head_r) begin
              mem_ra    = IDX_W'(ptr_r);
              state_nxt = bsl_pkg::S_EX;
            end else if (ptr_r + 1'b1 >= count_r) begin
              count_nxt = count_r - 1'b1;
              state_nxt = bsl_pkg::S_OUT;
            end else begin
              mem_ra    = IDX_W'(ptr_r + 1'b1);
              state_nxt = bsl_pkg::S_EX;
            end
          end
        endcase
      end

      // use the word just read
      bsl_pkg::S_EX: begin
        state_nxt = bsl_pkg::S_RD;
        case (kind_r)
          bsl_pkg::KIND_PREPEND: begin
            mem_we  = 1'b1;
            mem_wa  = IDX_W'(ptr_r);
            mem_wd  = rd_data_r;
            ptr_nxt = ptr_r - 1'b1;
          end
          bsl_pkg::KIND_SORTED: begin
            if (head_r) begin
              carry_nxt = rd_data_r;
              head_nxt  = 1'b0;
              ptr_nxt   = CNT_W'(1);
            end else begin
              mem_we = 1'b1;
              mem_wa = IDX_W'(ptr_r - 1'b1);
              if (cmp_res.gt) begin
                mem_wd   = rd_data_r;
                swap_nxt = 1'b1;
              end else begin
                mem_wd    = carry_r;
                carry_nxt = rd_data_r;
              end
              ptr_nxt = ptr_r + 1'b1;
            end
          end
          bsl_pkg::KIND_SEARCH: begin
            if (cmp_res.eq) begin
              found_nxt = 4'(ptr_r);
              state_nxt = bsl_pkg::S_OUT;
            end else begin
              ptr_nxt = ptr_r + 1'b1;
            end
          end
          default: begin
            if (head_r) begin
              removed_nxt = rd_data_r;
              head_nxt    = 1'b0;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = IDX_W'(ptr_r);
              mem_wd  = rd_data_r;
              ptr_nxt = ptr_r + 1'b1;
            end
          end
        endcase
      end

      // hand the result to the output register once it is free
      bsl_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = status_r;
          out_data_nxt.removed_value  = 32'($signed(removed_r));
          out_data_nxt.found_position = found_r;
          out_data_nxt.entry_count    = 5'(count_r);
          state_nxt                   = bsl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bsl_pkg::S_IDLE;
      end
    endcase
  end

  // checks
  `BSL_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(bsl_pkg::CAPACITY))
  `BSL_ASSERT_NEXT(a_count_step, 1'b1, count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 || count_r + 1'b1 == $past(count_r))
  `BSL_ASSERT_IMPLY(a_empty_reply, out_valid_r && out_data_r.status == bsl_pkg::ST_EMPTY, out_data_r.entry_count == 5'd0)
  `BSL_ASSERT_IMPLY(a_full_reply, out_valid_r && out_data_r.status == bsl_pkg::ST_FULL, out_data_r.entry_count == 5'(bsl_pkg::CAPACITY))

endmodule
